### hdl/cyclic_time_sensor_top_assert.svh
// Assertion macros shared by the checker.
`ifndef CYCLIC_TIME_SENSOR_TOP_ASSERT_SVH
`define CYCLIC_TIME_SENSOR_TOP_ASSERT_SVH
// a implies b in the same cycle
`define CTS_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("violation");
// a implies b in the next cycle
`define CTS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("violation");
`endif

### hdl/cts_pkg.sv
package cts_pkg;
  localparam int TimeWidth = 48;
  localparam int FracBits = 16;
  localparam int CycWidth = 32;
  localparam int FracWidth = FracBits + 1;
  localparam int DivCntWidth = $clog2(TimeWidth + 1);

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_STOP = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_LOOP = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_QUOT,
    ST_WAIT_Q,
    ST_FRAC,
    ST_WAIT_F,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic div_start;
    logic div_frac;
    logic use_stop;
    logic save_quot;
    logic save_frac;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic retired;
    logic en;
    logic active;
    logic before_start;
    logic past_stop;
    logic stop_on;
    logic div_done;
  } status_t;
endpackage

### hdl/cyclic_time_sensor_top.sv
// From request accept to result valid for ticks that give a fraction, the controller runs
// one 48-step integer divide, then one 16-step fraction divide.
// Disable while active: valid after DECIDE, FINISH; no-result requests end at DECIDE or FINISH.
// One request at a time: in_ready is low from accept until the result is taken or none is due.
// Reset: synchronous rst clears registers to start 0, stop 0, interval 1, loop 0,
// sensor inactive and not retired.
module cyclic_time_sensor_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [cts_pkg::TimeWidth-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [cts_pkg::TimeWidth-1:0] now,
  input  logic enable,
  output logic out_valid,
  input  logic out_ready,
  output logic is_active,
  output logic activated,
  output logic deactivated,
  output logic [cts_pkg::FracWidth-1:0] fraction,
  output logic fraction_valid,
  output logic [cts_pkg::TimeWidth-1:0] cycle_start,
  output logic cycle_start_valid,
  output logic time_valid
);
  cts_pkg::cmd_t cmd;
  cts_pkg::status_t stat;
  logic emit;

  // controller steps: latch request, decide, elapsed/iv (or stop offset/iv),
  // fraction of the time into the cycle, update state and result register
  cts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .emit(emit),
    .stat(stat), .cmd(cmd)
  );

  // datapath: config registers, sensor state, shared divider, cycle position,
  // result register held while out_valid waits
  cts_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .now(now), .enable(enable), .cmd(cmd), .stat(stat),
    .is_active(is_active), .activated(activated), .deactivated(deactivated),
    .fraction(fraction), .fraction_valid(fraction_valid), .cycle_start(cycle_start),
    .cycle_start_valid(cycle_start_valid), .time_valid(time_valid)
  );
endmodule

### hdl/cts_div.sv
// Restoring divider: one quotient bit per cycle.
// frac mode: floor(n*2^FracBits/d), n<d. else n/d and n%d.
module cts_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic frac_mode,
  input  logic [cts_pkg::TimeWidth-1:0] num,
  input  logic [cts_pkg::TimeWidth-1:0] den,
  output logic done,
  output logic [cts_pkg::TimeWidth-1:0] quot,
  output logic [cts_pkg::TimeWidth-1:0] rem
);
  logic busy;
  logic [cts_pkg::DivCntWidth-1:0] cnt;
  logic [cts_pkg::TimeWidth-1:0] sh;
  logic [cts_pkg::TimeWidth:0] trial;
  logic [cts_pkg::TimeWidth:0] r2;

  assign r2 = {rem, frac_mode ? 1'b0 : sh[cts_pkg::TimeWidth-1]};
  assign trial = r2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= frac_mode ? cts_pkg::DivCntWidth'(cts_pkg::FracBits)
                         : cts_pkg::DivCntWidth'(cts_pkg::TimeWidth);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cts_pkg::DivCntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= '0;
      rem <= frac_mode ? num : '0;
      sh <= num;
    end else if (busy) begin
      sh <= {sh[cts_pkg::TimeWidth-2:0], 1'b0};
      if (!trial[cts_pkg::TimeWidth]) begin
        rem <= trial[cts_pkg::TimeWidth-1:0];
        quot <= {quot[cts_pkg::TimeWidth-2:0], 1'b1};
      end else begin
        rem <= r2[cts_pkg::TimeWidth-1:0];
        quot <= {quot[cts_pkg::TimeWidth-2:0], 1'b0};
      end
    end
  end
endmodule

### hdl/cts_datapath.sv
module cts_datapath (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [cts_pkg::TimeWidth-1:0] cfg_data,
  input  logic [cts_pkg::TimeWidth-1:0] now,
  input  logic enable,
  input  cts_pkg::cmd_t cmd,
  output cts_pkg::status_t stat,
  output logic is_active,
  output logic activated,
  output logic deactivated,
  output logic [cts_pkg::FracWidth-1:0] fraction,
  output logic fraction_valid,
  output logic [cts_pkg::TimeWidth-1:0] cycle_start,
  output logic cycle_start_valid,
  output logic time_valid
);
  localparam int TW = cts_pkg::TimeWidth;
  localparam int CW = cts_pkg::CycWidth;
  localparam int FW = cts_pkg::FracWidth;
  localparam logic [FW-1:0] FracOne = FW'(1) << cts_pkg::FracBits;

  logic [TW-1:0] start_tick, stop_time, interval;
  logic loop_mode, active, retired;
  logic [CW-1:0] cycles_done, cycles_next;
  logic [TW-1:0] now_q;
  logic en_q;
  logic [TW-1:0] iv, elapsed, selap, q1, r1, ct_rem;
  logic [FW-1:0] nf;
  logic ct_ge;
  logic [TW-1:0] dnum;
  logic d_done;
  logic [TW-1:0] d_quot, d_rem;

  assign iv = (interval == '0) ? TW'(1) : interval;
  assign elapsed = now_q - start_tick;
  assign selap = stop_time - start_tick;

  // fraction divide works on the remainder; the integer divide on elapsed or the stop offset
  assign dnum = cmd.div_frac ? ct_rem : (cmd.use_stop ? selap : elapsed);

  cts_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .frac_mode(cmd.div_frac),
    .num(dnum), .den(iv), .done(d_done), .quot(d_quot), .rem(d_rem)
  );

  cts_seq u_seq (
    .quot(q1), .rem(r1), .cycles_done(cycles_done),
    .ct_rem(ct_rem), .ct_ge(ct_ge), .cycles_next(cycles_next)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now_q <= now;
      en_q <= enable;
    end
    if (cmd.save_quot) begin
      q1 <= d_quot;
      r1 <= d_rem;
    end
    if (cmd.save_frac) nf <= FW'(d_quot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tick <= '0;
      stop_time <= '0;
      interval <= TW'(1);
      loop_mode <= 1'b0;
      active <= 1'b0;
      retired <= 1'b0;
      cycles_done <= '0;
    end else if (cfg_we) begin
      unique case (cts_pkg::reg_idx_t'(cfg_index))
        cts_pkg::REG_START: start_tick <= cfg_data;
        cts_pkg::REG_STOP: stop_time <= cfg_data;
        cts_pkg::REG_INTERVAL: interval <= cfg_data;
        cts_pkg::REG_LOOP: loop_mode <= cfg_data[0];
      endcase
      retired <= 1'b0;
    end else if (cmd.finish) begin
      if (!en_q) begin
        if (active) begin
          active <= 1'b0; retired <= 1'b1; cycles_done <= '0;
        end
      end else if (!active && stat.stop_on && stat.past_stop) begin
        retired <= 1'b1;
      end else if (active && stat.stop_on && stat.past_stop) begin
        active <= 1'b0; retired <= 1'b1; cycles_done <= '0;
      end else if (active && !loop_mode && ct_ge) begin
        active <= 1'b0; retired <= 1'b1; cycles_done <= '0;
      end else begin
        active <= 1'b1;
        if (loop_mode && ct_ge) cycles_done <= cycles_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      activated <= 1'b0; deactivated <= 1'b0; fraction <= '0; fraction_valid <= 1'b0;
      cycle_start <= '0; cycle_start_valid <= 1'b0; time_valid <= 1'b0;
      is_active <= active;
      if (!en_q) begin
        cycle_start <= now_q; cycle_start_valid <= 1'b1; deactivated <= 1'b1;
        is_active <= 1'b0;
      end else if (active && stat.stop_on && stat.past_stop) begin
        // nf holds the fraction at stop time on this path
        time_valid <= 1'b1; fraction <= (nf == '0) ? FracOne : nf; fraction_valid <= 1'b1;
        deactivated <= 1'b1; is_active <= 1'b0;
      end else if (active && !loop_mode && ct_ge) begin
        time_valid <= 1'b1; fraction <= FracOne; fraction_valid <= 1'b1;
        deactivated <= 1'b1; is_active <= 1'b0;
      end else begin
        is_active <= 1'b1;
        fraction_valid <= 1'b1;
        if (active) begin
          time_valid <= 1'b1;
          fraction <= (nf == '0 && now_q > start_tick) ? FracOne : nf;
        end else begin
          activated <= 1'b1; cycle_start <= now_q; cycle_start_valid <= 1'b1;
          fraction <= nf;
        end
        if (loop_mode && ct_ge) begin
          cycle_start <= now_q - ct_rem; cycle_start_valid <= 1'b1;
        end
      end
    end
  end

  assign stat.retired = retired;
  assign stat.en = en_q;
  assign stat.active = active;
  assign stat.before_start = now_q < start_tick;
  assign stat.past_stop = now_q >= stop_time;
  assign stat.stop_on = stop_time > start_tick;
  assign stat.div_done = d_done;
endmodule

### hdl/cts_ctrl.sv
module cts_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic emit,
  input  cts_pkg::status_t stat,
  output cts_pkg::cmd_t cmd
);
  cts_pkg::state_t state, state_next;
  logic emit_next;
  logic stop_hit;

  // active sensor reaching stop time: divide the stop offset instead of the elapsed time
  assign stop_hit = stat.active && stat.stop_on && stat.past_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cts_pkg::ST_IDLE;
      emit <= 1'b0;
    end else begin
      state <= state_next;
      emit <= emit_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    emit_next = emit;
    unique case (state)
      cts_pkg::ST_IDLE: if (in_valid) state_next = cts_pkg::ST_DECIDE;
      cts_pkg::ST_DECIDE: begin
        emit_next = 1'b1;
        priority if (stat.retired) begin
          state_next = cts_pkg::ST_IDLE;
          emit_next = 1'b0;
        end else if (!stat.en) begin
          state_next = cts_pkg::ST_FINISH;
          emit_next = stat.active;
        end else if (stat.before_start) begin
          state_next = cts_pkg::ST_IDLE;
          emit_next = 1'b0;
        end else if (!stat.active && stat.stop_on && stat.past_stop) begin
          state_next = cts_pkg::ST_FINISH;
          emit_next = 1'b0;
        end else begin
          state_next = cts_pkg::ST_QUOT;
        end
      end
      cts_pkg::ST_QUOT: state_next = cts_pkg::ST_WAIT_Q;
      cts_pkg::ST_WAIT_Q: if (stat.div_done) state_next = cts_pkg::ST_FRAC;
      cts_pkg::ST_FRAC: state_next = cts_pkg::ST_WAIT_F;
      cts_pkg::ST_WAIT_F: if (stat.div_done) state_next = cts_pkg::ST_FINISH;
      cts_pkg::ST_FINISH: state_next = emit ? cts_pkg::ST_OUT : cts_pkg::ST_IDLE;
      cts_pkg::ST_OUT: if (out_ready) state_next = cts_pkg::ST_IDLE;
      default: state_next = cts_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = (state == cts_pkg::ST_IDLE);
    out_valid = (state == cts_pkg::ST_OUT);
    unique case (state)
      cts_pkg::ST_IDLE: cmd.latch = in_valid;
      cts_pkg::ST_QUOT: begin
        cmd.div_start = 1'b1;
        cmd.use_stop = stop_hit;
      end
      cts_pkg::ST_WAIT_Q: cmd.save_quot = stat.div_done;
      cts_pkg::ST_FRAC: begin
        cmd.div_start = 1'b1;
        cmd.div_frac = 1'b1;
      end
      cts_pkg::ST_WAIT_F: begin
        cmd.div_frac = 1'b1;
        cmd.save_frac = stat.div_done;
      end
      cts_pkg::ST_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end
endmodule

### hdl/cts_seq.sv
// Position inside the current cycle from elapsed/iv (quot, rem) and the completed-cycle count.
// ct = elapsed - cycles_done*iv = (quot - cycles_done)*iv + rem, so no multiply is needed.
module cts_seq (
  input  logic [cts_pkg::TimeWidth-1:0] quot,
  input  logic [cts_pkg::TimeWidth-1:0] rem,
  input  logic [cts_pkg::CycWidth-1:0] cycles_done,
  output logic [cts_pkg::TimeWidth-1:0] ct_rem,
  output logic ct_ge,
  output logic [cts_pkg::CycWidth-1:0] cycles_next
);
  localparam int WW = cts_pkg::TimeWidth + cts_pkg::CycWidth;

  logic behind;
  logic [WW-1:0] whole, room;

  // completed count ahead of the elapsed time: time into the cycle reads as zero
  assign behind = WW'(quot) < WW'(cycles_done);
  assign whole = WW'(quot) - WW'(cycles_done);
  assign ct_rem = behind ? '0 : rem;
  assign ct_ge = !behind && (whole != '0);

  // saturating add of the whole cycles passed
  assign room = WW'({cts_pkg::CycWidth{1'b1}} - cycles_done);
  assign cycles_next = (whole > room) ? '1 : cycles_done + cts_pkg::CycWidth'(whole);
endmodule

### hdl/cts_checker.sv
`include "cyclic_time_sensor_top_assert.svh"
module cts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic activated,
  input logic deactivated,
  input logic is_active
);
  `CTS_ASSERT_IMP(a_no_both, out_valid, !(in_ready))
  `CTS_ASSERT_IMP(a_act_flag, out_valid && activated, is_active && !deactivated)
  `CTS_ASSERT_IMP(a_deact_flag, out_valid && deactivated, !is_active)
  `CTS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
  `CTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
endmodule

bind cyclic_time_sensor_top cts_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .activated(activated),
  .deactivated(deactivated), .is_active(is_active)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

// Fields of one sensor result, at the block's widths.
typedef struct packed {
  logic                          is_active;
  logic                          activated;
  logic                          deactivated;
  logic [cts_pkg::FracWidth-1:0] fraction;
  logic                          fraction_valid;
  logic [cts_pkg::TimeWidth-1:0] cycle_start;
  logic                          cycle_start_valid;
  logic                          time_valid;
} sense_t;

// Sensor predictor plus the queue of expected results.
class sensor_scoreboard;
  localparam int TW = cts_pkg::TimeWidth;
  localparam int FW = cts_pkg::FracWidth;
  localparam logic [63:0] CMAX = (64'd1 << cts_pkg::CycWidth) - 1;
  localparam logic [63:0] ONE = 64'd1 << cts_pkg::FracBits;

  logic [63:0] start_t, stop_t, ivl_reg;
  bit          loop_m, on, retired;
  logic [63:0] cycles;
  sense_t      pending[$];
  int          mismatches, results, activations, deactivations;

  function void clear();
    start_t = 0; stop_t = 0; ivl_reg = 1; loop_m = 0;
    on = 0; retired = 0; cycles = 0;
  endfunction

  function void write_reg(cts_pkg::reg_idx_t idx, logic [cts_pkg::TimeWidth-1:0] val);
    case (idx)
      cts_pkg::REG_START:    start_t = val;
      cts_pkg::REG_STOP:     stop_t = val;
      cts_pkg::REG_INTERVAL: ivl_reg = val;
      cts_pkg::REG_LOOP:     loop_m = val[0];
    endcase
    retired = 0;
  endfunction

  function logic [63:0] frac_of(logic [63:0] r, logic [63:0] iv);
    logic [63:0] q;
    bit carry;
    q = 0;
    for (int i = 0; i < cts_pkg::FracBits; i++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= iv) begin
        r = r - iv;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function logic [63:0] time_in_cycle(logic [63:0] elapsed, logic [63:0] iv);
    if (cycles > elapsed / iv) return 0;
    return elapsed - cycles * iv;
  endfunction

  function void retire();
    on = 0; retired = 1; cycles = 0;
  endfunction

  // returns 1 and fills r when the tick yields a result
  function bit predict(logic [63:0] now, bit en, output sense_t r);
    bit stop_on;
    logic [63:0] iv, ct, nf, inc, f;
    r = '0;
    stop_on = stop_t > start_t;
    iv = (ivl_reg == 0) ? 64'd1 : ivl_reg;
    if (retired) return 0;
    if (!en) begin
      if (!on) return 0;
      r.cycle_start = TW'(now);
      r.cycle_start_valid = 1;
      retire();
      r.deactivated = 1;
      return 1;
    end
    if (now < start_t) return 0;
    if (!on && stop_on && now >= stop_t) begin
      retired = 1;
      return 0;
    end
    ct = time_in_cycle(now - start_t, iv);
    nf = frac_of(ct % iv, iv);
    if (on) begin
      r.time_valid = 1;
      if (nf == 0 && now > start_t) nf = ONE;
      if (stop_on && now >= stop_t) begin
        f = frac_of(time_in_cycle(stop_t - start_t, iv) % iv, iv);
        r.fraction = FW'((f == 0) ? ONE : f);
        r.fraction_valid = 1;
        retire();
        r.deactivated = 1;
        return 1;
      end
      if (!loop_m && ct >= iv) begin
        r.fraction = FW'(ONE);
        r.fraction_valid = 1;
        retire();
        r.deactivated = 1;
        return 1;
      end
      r.fraction = FW'(nf);
      r.fraction_valid = 1;
    end else begin
      on = 1;
      retired = 0;
      r.activated = 1;
      r.cycle_start = TW'(now);
      r.cycle_start_valid = 1;
      r.fraction = FW'(nf);
      r.fraction_valid = 1;
    end
    if (loop_m && ct >= iv) begin
      inc = ct / iv;
      if (inc > CMAX - cycles) cycles = CMAX;
      else cycles = cycles + inc;
      r.cycle_start = TW'(now - (ct % iv));
      r.cycle_start_valid = 1;
    end
    r.is_active = on;
    return 1;
  endfunction

  function void note_request(logic [cts_pkg::TimeWidth-1:0] now, bit en);
    sense_t r;
    if (predict(64'(now), en, r)) pending.push_back(r);
  endfunction

  function void check_result(sense_t got);
    sense_t exp_r;
    results++;
    if (got.activated) activations++;
    if (got.deactivated) deactivations++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
    end
  endfunction
endclass

module tb_top;
  localparam logic [63:0] TMAX = (64'd1 << cts_pkg::TimeWidth) - 1;
  localparam int WATCHDOG = 20000;
  // margin for a request with no result to finish before register writes
  localparam int SETTLE = 250;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [cts_pkg::TimeWidth-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [cts_pkg::TimeWidth-1:0] now = '0;
  logic enable = 0;
  logic out_valid;
  logic out_ready = 0;
  logic is_active, activated, deactivated, fraction_valid, cycle_start_valid, time_valid;
  logic [cts_pkg::FracWidth-1:0] fraction;
  logic [cts_pkg::TimeWidth-1:0] cycle_start;

  sensor_scoreboard sb = new();
  int requests = 0;
  int phases = 0;
  int idle_cycles = 0;
  bit hold_off = 0;

  always #2 clk = ~clk;

  cyclic_time_sensor_top i_dut (.*);

  // Result side: compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({is_active, activated, deactivated, fraction, fraction_valid,
                       cycle_start, cycle_start_valid, time_valid});
  end

  // Watchdog: any handshake or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", sb.pending.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Receiver: random back-pressure; hold_off forces one long stall so the
  // block backs up and stops taking requests.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic logic [63:0] rand_time();
    return {$urandom, $urandom} & TMAX;
  endfunction

  task automatic send(logic [63:0] t, bit en);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    now <= t[cts_pkg::TimeWidth-1:0];
    enable <= en;
    do @(posedge clk); while (!in_ready);
    sb.note_request(t[cts_pkg::TimeWidth-1:0], en);
    requests++;
  endtask

  // Drain outstanding results, then let a no-result request finish too.
  task automatic settle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(cts_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[cts_pkg::TimeWidth-1:0];
    @(posedge clk);
    sb.write_reg(idx, val[cts_pkg::TimeWidth-1:0]);
  endtask

  task automatic configure(logic [63:0] st, logic [63:0] sp, logic [63:0] iv, bit lp);
    settle();
    set_reg(cts_pkg::REG_START, st);
    set_reg(cts_pkg::REG_STOP, sp);
    set_reg(cts_pkg::REG_INTERVAL, iv);
    set_reg(cts_pkg::REG_LOOP, lp);
    cfg_we <= 0;
    phases++;
  endtask

  initial begin
    logic [63:0] st, sp, iv, cur, stp;
    bit lp;
    int n;
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, activation at zero then end of a one-shot cycle.
    send(0, 1);
    send(5, 1);
    send(6, 1);                        // retired: ignored
    // before start, disable while idle, activate, loop wrap, disable while active
    configure(100, 0, 10, 1);
    send(50, 1);
    send(120, 0);
    send(100, 1);
    send(125, 1);
    send(160, 1);
    send(170, 1);                      // exact cycle boundary reads as one
    send(171, 0);
    // stop reached while active, and past stop while inactive
    configure(1000, 1037, 16, 1);
    send(1010, 1);
    send(1030, 1);
    send(5000, 1);
    configure(1000, 1037, 16, 1);
    send(2000, 1);
    // zero interval, all-ones time, counter saturation
    configure(0, 0, 0, 1);
    send(0, 1);
    send(TMAX, 1);
    send(TMAX, 1);
    configure(TMAX, 0, TMAX, 0);
    send(TMAX - 1, 1);
    send(TMAX, 1);
    send(TMAX, 1);
    // register change while active: shorter interval mid-cycle
    configure(0, 0, 1000, 1);
    send(10, 1);
    send(2500, 1);
    settle();
    set_reg(cts_pkg::REG_INTERVAL, 7);
    cfg_we <= 0;
    send(2501, 1);
    send(2600, 1);

    // Random phases of mostly well-formed tick sequences.
    while (requests < 1750) begin
      case ($urandom_range(0, 9))
        0: st = 0;
        1, 2: st = rand_time();
        3: st = TMAX - $urandom_range(0, 5000);
        default: st = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 19))
        0: iv = rand_time() | 1;
        1, 2, 3, 4: iv = $urandom_range(41, 5000);
        default: iv = $urandom_range(1, 40);
      endcase
      if ($urandom_range(0, 9) < 4) sp = (st > 0) ? st - $urandom_range(0, 3) : 0;
      else sp = st + $urandom_range(1, 6) * iv + $urandom_range(0, 3);
      if (sp > TMAX) sp = TMAX;
      lp = $urandom_range(0, 1);
      settle();
      if (phases < 8 || $urandom_range(0, 3) != 0) set_reg(cts_pkg::REG_START, st);
      else st = sb.start_t;
      if ($urandom_range(0, 3) != 0) set_reg(cts_pkg::REG_STOP, sp);
      if ($urandom_range(0, 3) != 0) set_reg(cts_pkg::REG_INTERVAL, iv);
      else iv = (sb.ivl_reg == 0) ? 1 : sb.ivl_reg;
      set_reg(cts_pkg::REG_LOOP, lp);
      cfg_we <= 0;
      phases++;
      if (phases == 30) hold_off = 1;
      cur = (st > 3) ? st - $urandom_range(0, 3) : st;
      n = $urandom_range(5, 35);
      for (int k = 0; k < n && !sb.retired; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send(rand_time(), $urandom_range(0, 1));
        end else begin
          if (iv < 64) stp = $urandom_range(0, 2 * iv);
          else stp = (iv >> $urandom_range(0, 6)) + $urandom_range(0, 3);
          cur = (cur + stp > TMAX) ? TMAX : cur + stp;
          send(cur, $urandom_range(0, 19) != 0);
        end
      end
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d ticks over %0d register settings", requests, phases);
    $display("%0d results checked: %0d activations, %0d deactivations, %0d mismatches",
             sb.results, sb.activations, sb.deactivations, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule
